// File: rtl/ddo_pkg.sv
// Shared types, constants and helper functions for the wheel odometry block.
// No dependencies; used by rtl/diff_drive_odometry.sv, its checker and the testbench.
package ddo_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STEPS  = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] RAD_TO_BAM  = 34'sd683565276;
  localparam logic signed [33:0] US_PER_S    = 34'sd1000000;
  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;

  // Register byte addresses on the configuration port
  localparam logic [2:0] ADDR_RADIUS     = 3'd0;
  localparam logic [2:0] ADDR_SEPARATION = 3'd4;

  typedef struct packed {
    logic signed [31:0] left_wheel_pos;
    logic signed [31:0] right_wheel_pos;
    logic        [31:0] timestamp_us;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] linear_vel;
    logic signed [31:0] angular_vel;
    logic               dt_zero;
  } pose_t;

  // CORDIC rotation angles as binary angles, 2^32 per turn
  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/diff_drive_odometry.sv
// Differential-drive wheel odometry: pose, heading quaternion and velocities; uses ddo_pkg.
// From sample beat to pose beat: three restoring divider passes (one on a zero time step, one
//   fewer on a zero separation) and two 30-step CORDIC passes.
// A new sample is taken only once the last pose is offered; sample_stall is high from accept
//   to result offer, longer while a finished pose waits behind a stalled pose beat.
// Reset (rst, synchronous): clears pose, previous sample and handshake state, loads defaults.
module diff_drive_odometry (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  ddo_pkg::sample_t   sample,
  // pose channel
  output logic               pose_valid,
  input  logic               pose_stall,
  output ddo_pkg::pose_t     pose,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_MUL_S    = 5'd1;
  localparam logic [4:0] ST_DS       = 5'd2;
  localparam logic [4:0] ST_MUL_T    = 5'd3;
  localparam logic [4:0] ST_QDIV     = 5'd4;
  localparam logic [4:0] ST_DIV      = 5'd5;
  localparam logic [4:0] ST_QEND     = 5'd6;
  localparam logic [4:0] ST_BAM_HI   = 5'd7;
  localparam logic [4:0] ST_BAM_ACC  = 5'd8;
  localparam logic [4:0] ST_BAM_LO   = 5'd9;
  localparam logic [4:0] ST_HEAD     = 5'd10;
  localparam logic [4:0] ST_CORD     = 5'd11;
  localparam logic [4:0] ST_MUL_X    = 5'd12;
  localparam logic [4:0] ST_POS_X    = 5'd13;
  localparam logic [4:0] ST_MUL_Y    = 5'd14;
  localparam logic [4:0] ST_POS_Y    = 5'd15;
  localparam logic [4:0] ST_LIN_MUL  = 5'd16;
  localparam logic [4:0] ST_LIN_DIV  = 5'd17;
  localparam logic [4:0] ST_LIN_END  = 5'd18;
  localparam logic [4:0] ST_ANG_MULH = 5'd19;
  localparam logic [4:0] ST_ANG_ACC  = 5'd20;
  localparam logic [4:0] ST_ANG_MULL = 5'd21;
  localparam logic [4:0] ST_ANG_DIV  = 5'd22;
  localparam logic [4:0] ST_ANG_END  = 5'd23;
  localparam logic [4:0] ST_HALF     = 5'd24;
  localparam logic [4:0] ST_DONE     = 5'd25;

  logic [4:0] state;
  logic [4:0] div_ret;
  logic [4:0] cord_ret;

  // Configuration registers
  logic [15:0] radius;
  logic [19:0] separation;

  // Architectural state
  logic [31:0]        prev_left_pos;
  logic [31:0]        prev_right_pos;
  logic [31:0]        prev_timestamp;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic [31:0]        heading_angle;

  // Per-beat working registers
  logic signed [31:0] dl;
  logic signed [31:0] dr;
  logic [31:0]        dt;
  logic signed [31:0] ds;
  logic signed [49:0] q;
  logic [31:0]        bam_acc;
  logic signed [63:0] ang_acc;
  logic signed [31:0] lin;
  logic signed [31:0] ang;

  // Shared multiplier: operands picked by state, product registered
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [67:0] mul_abs;

  // Shared restoring divider (unsigned magnitude, sign applied after)
  logic [63:0] div_quo;
  logic [31:0] div_rem;
  logic [31:0] div_den;
  logic        div_neg;
  logic [5:0]  div_cnt;
  logic [32:0] div_shift;
  logic        div_ge;
  logic signed [65:0] div_signed;

  // Shared CORDIC rotator
  logic signed [33:0] cord_x;
  logic signed [33:0] cord_y;
  logic signed [32:0] cord_z;
  logic [1:0]         cord_quad;
  logic [4:0]         cord_cnt;
  logic signed [33:0] cord_xs;
  logic signed [33:0] cord_ys;
  logic signed [32:0] cord_atan;
  logic signed [34:0] cs_raw;
  logic signed [34:0] sn_raw;
  logic signed [31:0] cs;
  logic signed [31:0] sn;

  logic signed [41:0] qc;
  logic signed [63:0] ang_num;
  logic [63:0]        ang_mag;
  logic [31:0]        heading_next;
  logic signed [65:0] pos_sum;
  logic               cfg_wr;

  assign pready       = 1'b1;
  assign sample_stall = (state != ST_IDLE);
  assign cfg_wr       = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      ddo_pkg::ADDR_RADIUS:     prdata = {16'd0, radius};
      ddo_pkg::ADDR_SEPARATION: prdata = {12'd0, separation};
      default:                  prdata = 32'd0;
    endcase
  end

  // Heading increment for velocity is clamped to +-2^24 rad (Q16.16)
  always_comb begin
    if (q > 50'sd1099511627776) begin
      qc = 42'sd1099511627776;
    end else if (q < -50'sd1099511627776) begin
      qc = -42'sd1099511627776;
    end else begin
      qc = q[41:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_S: begin
        mul_a = {18'd0, radius};
        mul_b = {{2{dl[31]}}, dl} + {{2{dr[31]}}, dr};
      end
      ST_MUL_T: begin
        mul_a = {18'd0, radius};
        mul_b = {{2{dr[31]}}, dr} - {{2{dl[31]}}, dl};
      end
      ST_BAM_HI: begin
        mul_a = {2'd0, q[47:16]};
        mul_b = ddo_pkg::RAD_TO_BAM;
      end
      ST_BAM_LO: begin
        mul_a = {18'd0, q[15:0]};
        mul_b = ddo_pkg::RAD_TO_BAM;
      end
      ST_MUL_X: begin
        mul_a = {{2{ds[31]}}, ds};
        mul_b = {{2{cs[31]}}, cs};
      end
      ST_MUL_Y: begin
        mul_a = {{2{ds[31]}}, ds};
        mul_b = {{2{sn[31]}}, sn};
      end
      ST_LIN_MUL: begin
        mul_a = {{2{ds[31]}}, ds};
        mul_b = ddo_pkg::US_PER_S;
      end
      ST_ANG_MULH: begin
        mul_a = {{12{qc[41]}}, qc[41:20]};
        mul_b = ddo_pkg::US_PER_S;
      end
      ST_ANG_MULL: begin
        mul_a = {14'd0, qc[19:0]};
        mul_b = ddo_pkg::US_PER_S;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_abs = mul_p[67] ? -mul_p : mul_p;

  // Divider step
  assign div_shift  = {div_rem, div_quo[63]};
  assign div_ge     = (div_shift >= {1'b0, div_den});
  assign div_signed = div_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

  assign ang_num = ang_acc + mul_p[63:0];
  assign ang_mag = ang_num[63] ? 64'(-ang_num) : 64'(ang_num);

  // CORDIC step and quadrant fold
  assign cord_xs   = cord_x >>> cord_cnt;
  assign cord_ys   = cord_y >>> cord_cnt;
  assign cord_atan = $signed({3'd0, ddo_pkg::atan_bam(cord_cnt)});

  always_comb begin
    unique case (cord_quad)
      2'd0: begin
        cs_raw = {cord_x[33], cord_x};
        sn_raw = {cord_y[33], cord_y};
      end
      2'd1: begin
        cs_raw = -{cord_y[33], cord_y};
        sn_raw = {cord_x[33], cord_x};
      end
      2'd2: begin
        cs_raw = -{cord_x[33], cord_x};
        sn_raw = -{cord_y[33], cord_y};
      end
      default: begin
        cs_raw = {cord_y[33], cord_y};
        sn_raw = -{cord_x[33], cord_x};
      end
    endcase
  end

  assign cs = (cs_raw > ddo_pkg::ONE_Q30) ? 32'(ddo_pkg::ONE_Q30) :
              (cs_raw < -ddo_pkg::ONE_Q30) ? 32'(-ddo_pkg::ONE_Q30) : cs_raw[31:0];
  assign sn = (sn_raw > ddo_pkg::ONE_Q30) ? 32'(ddo_pkg::ONE_Q30) :
              (sn_raw < -ddo_pkg::ONE_Q30) ? 32'(-ddo_pkg::ONE_Q30) : sn_raw[31:0];

  // New heading: old heading plus (q * RAD_TO_BAM) >> 16, built from the high and low halves of q
  assign heading_next = heading_angle + bam_acc + mul_p[47:16];

  // Position step is floor(ds * trig / 2^30), then saturate
  always_comb begin
    if (state == ST_POS_X) begin
      pos_sum = {{34{x_position[31]}}, x_position} + 66'(mul_p >>> 30);
    end else begin
      pos_sum = {{34{y_position[31]}}, y_position} + 66'(mul_p >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= 16'd2163;
      separation <= 20'd11141;
    end else if (cfg_wr && pready) begin
      if (paddr == ddo_pkg::ADDR_SEPARATION) begin
        separation <= pwdata[19:0];
      end else if (paddr == ddo_pkg::ADDR_RADIUS) begin
        radius <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pose_valid     <= 1'b0;
      prev_left_pos  <= '0;
      prev_right_pos <= '0;
      prev_timestamp <= '0;
      x_position     <= '0;
      y_position     <= '0;
      heading_angle  <= '0;
    end else begin
      // drop the result once the consumer takes it; the final state reloads it itself
      if (pose_valid && !pose_stall && state != ST_DONE) begin
        pose_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            dl             <= sample.left_wheel_pos - prev_left_pos;
            dr             <= sample.right_wheel_pos - prev_right_pos;
            dt             <= sample.timestamp_us - prev_timestamp;
            prev_left_pos  <= sample.left_wheel_pos;
            prev_right_pos <= sample.right_wheel_pos;
            prev_timestamp <= sample.timestamp_us;
            state          <= ST_MUL_S;
          end
        end
        ST_MUL_S: state <= ST_DS;
        ST_DS: begin
          // travelled distance: floor(r*(dl+dr) / 2^17)
          ds    <= mul_p[48:17];
          state <= ST_MUL_T;
        end
        ST_MUL_T: state <= ST_QDIV;
        ST_QDIV: begin
          if (separation == 20'd0) begin
            q     <= '0;
            state <= ST_BAM_HI;
          end else begin
            div_quo <= mul_abs[63:0];
            div_rem <= '0;
            div_den <= {12'd0, separation};
            div_neg <= mul_p[67];
            div_cnt <= '0;
            div_ret <= ST_QEND;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_rem <= div_ge ? 32'(div_shift - {1'b0, div_den}) : div_shift[31:0];
          div_quo <= {div_quo[62:0], div_ge};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) begin
            state <= div_ret;
          end
        end
        ST_QEND: begin
          q     <= div_signed[49:0];
          state <= ST_BAM_HI;
        end
        ST_BAM_HI:  state <= ST_BAM_ACC;
        ST_BAM_ACC: begin
          bam_acc <= mul_p[31:0];
          state   <= ST_BAM_LO;
        end
        ST_BAM_LO: state <= ST_HEAD;
        ST_HEAD: begin
          heading_angle <= heading_next;
          cord_x        <= ddo_pkg::CORDIC_GAIN;
          cord_y        <= '0;
          cord_z        <= {3'd0, heading_next[29:0]};
          cord_quad     <= heading_next[31:30];
          cord_cnt      <= '0;
          cord_ret      <= ST_MUL_X;
          state         <= ST_CORD;
        end
        ST_CORD: begin
          if (cord_z >= 0) begin
            cord_x <= cord_x - cord_ys;
            cord_y <= cord_y + cord_xs;
            cord_z <= cord_z - cord_atan;
          end else begin
            cord_x <= cord_x + cord_ys;
            cord_y <= cord_y - cord_xs;
            cord_z <= cord_z + cord_atan;
          end
          cord_cnt <= cord_cnt + 5'd1;
          if (cord_cnt == 5'(ddo_pkg::CORDIC_STEPS - 1)) begin
            state <= cord_ret;
          end
        end
        ST_MUL_X: state <= ST_POS_X;
        ST_POS_X: begin
          x_position <= ddo_pkg::sat32(pos_sum);
          state      <= ST_MUL_Y;
        end
        ST_MUL_Y: state <= ST_POS_Y;
        ST_POS_Y: begin
          y_position <= ddo_pkg::sat32(pos_sum);
          if (dt == 32'd0) begin
            lin   <= '0;
            ang   <= '0;
            state <= ST_HALF;
          end else begin
            state <= ST_LIN_MUL;
          end
        end
        ST_LIN_MUL: state <= ST_LIN_DIV;
        ST_LIN_DIV: begin
          div_quo <= mul_abs[63:0];
          div_rem <= '0;
          div_den <= dt;
          div_neg <= mul_p[67];
          div_cnt <= '0;
          div_ret <= ST_LIN_END;
          state   <= ST_DIV;
        end
        ST_LIN_END: begin
          lin   <= ddo_pkg::sat32(div_signed);
          state <= ST_ANG_MULH;
        end
        ST_ANG_MULH: state <= ST_ANG_ACC;
        ST_ANG_ACC: begin
          ang_acc <= {mul_p[43:0], 20'd0};
          state   <= ST_ANG_MULL;
        end
        ST_ANG_MULL: state <= ST_ANG_DIV;
        ST_ANG_DIV: begin
          div_quo <= ang_mag;
          div_rem <= '0;
          div_den <= dt;
          div_neg <= ang_num[63];
          div_cnt <= '0;
          div_ret <= ST_ANG_END;
          state   <= ST_DIV;
        end
        ST_ANG_END: begin
          ang   <= ddo_pkg::sat32(div_signed);
          state <= ST_HALF;
        end
        ST_HALF: begin
          // quaternion needs sin and cos of half the heading
          cord_x    <= ddo_pkg::CORDIC_GAIN;
          cord_y    <= '0;
          cord_z    <= {3'd0, heading_angle[30:1]};
          cord_quad <= {1'b0, heading_angle[31]};
          cord_cnt  <= '0;
          cord_ret  <= ST_DONE;
          state     <= ST_CORD;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!pose_valid || !pose_stall) begin
            pose.pos_x       <= x_position;
            pose.pos_y       <= y_position;
            pose.heading     <= heading_angle;
            pose.quat_z      <= sn;
            pose.quat_w      <= cs;
            pose.linear_vel  <= lin;
            pose.angular_vel <= ang;
            pose.dt_zero     <= (dt == 32'd0);
            pose_valid       <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ddo_checker.sv
// Port-level checks for the wheel odometry block, bound to its top level.
// Depends on ddo_pkg and rtl/diff_drive_odometry.sv.
module ddo_checker (
  input logic           clk,
  input logic           rst,
  input logic           sample_valid,
  input logic           sample_stall,
  input logic           pose_valid,
  input logic           pose_stall,
  input ddo_pkg::pose_t pose
);

  // a stalled result stays offered
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pose_stall |=> pose_valid)
    else $error("pose beat dropped while stalled");

  // the block is busy in the cycle after a sample beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample accepted back to back");

  // zero time step forces both velocities to zero
  a_dt_zero: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pose.dt_zero |-> pose.linear_vel == 32'sd0 && pose.angular_vel == 32'sd0)
    else $error("velocity nonzero on zero time step");

  // quaternion parts stay within +-1.0 in Q1.30
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> pose.quat_z <= 32'sd1073741824 && pose.quat_z >= -32'sd1073741824 &&
                   pose.quat_w <= 32'sd1073741824 && pose.quat_w >= -32'sd1073741824)
    else $error("quaternion component out of range");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .pose_valid   (pose_valid),
  .pose_stall   (pose_stall),
  .pose         (pose)
);

// File: tb/diff_drive_odometry_test.sv
// Self-checking testbench for diff_drive_odometry: drives wheel-angle samples,
// predicts each pose beat with an in-bench fixed-point odometry model and compares.
// Depends on rtl/ddo_pkg.sv and rtl/diff_drive_odometry.sv.
module diff_drive_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint     CYCLE_LIMIT     = 4000000;
  localparam int         DRAIN_CYCLES    = 320;  // a bit over one beat of latency
  localparam int         HOLD_CYCLES     = 4000;

  // CORDIC step angles, binary angle units (2^32 per turn)
  localparam longint STEP_ANGLE [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1};

  logic    clk, rst;
  logic    sample_valid, sample_stall;
  ddo_pkg::sample_t sample;
  logic    pose_valid, pose_stall;
  ddo_pkg::pose_t   pose;
  logic    psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  diff_drive_odometry DUT (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .pose_valid, .pose_stall, .pose,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  // Odometry state mirrored in the bench
  logic [15:0] radius_q;
  logic [19:0] separation_q;
  logic [31:0] last_left, last_right, last_ts;
  logic signed [31:0] odo_x, odo_y;
  logic [31:0] odo_heading;

  ddo_pkg::sample_t pending_samples [$];
  ddo_pkg::pose_t   expected_poses [$];
  int      mismatches, poses_seen, dt_zero_seen, sat_seen;
  int      send_idle_pct, recv_stall_pct;
  int      hold_left;
  logic    hold_off;
  longint  cycle_count;

  // Stimulus generator state
  logic [31:0] gen_left, gen_right, gen_ts;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotate a binary angle through 30 CORDIC steps, fold back the quadrant
  function automatic void rotate_angle(input logic [31:0] a, output longint sn,
                                       output longint cs);
    longint x, y, z, xs, ys, c, s;
    x = ddo_pkg::CORDIC_GAIN;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= STEP_ANGLE[i];
      end else begin
        x += ys; y -= xs; z += STEP_ANGLE[i];
      end
    end
    case (a[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cs = clamp(c, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    sn = clamp(s, -(64'sd1 <<< 30), 64'sd1 <<< 30);
  endfunction

  // floor(d * t / 2^30), split to stay inside 64 bits
  function automatic longint step_q30(longint d, longint t);
    longint hi, lo;
    hi = d >>> 16;
    lo = d - hi * 65536;
    return (hi * t + ((lo * t) >>> 16)) >>> 14;
  endfunction

  function automatic ddo_pkg::pose_t odometry_step(ddo_pkg::sample_t s);
    longint dl, dr, dt, r, d_s, q, sn, cs, lin, ang;
    logic [31:0] d_bam;
    longint unsigned prod;
    ddo_pkg::pose_t p;
    dl = longint'($signed(s.left_wheel_pos - last_left));
    dr = longint'($signed(s.right_wheel_pos - last_right));
    dt = longint'({32'd0, s.timestamp_us - last_ts});
    r  = longint'(radius_q);
    last_left  = s.left_wheel_pos;
    last_right = s.right_wheel_pos;
    last_ts    = s.timestamp_us;
    d_s = (r * (dl + dr)) >>> (ddo_pkg::FRAC_BITS + 1);
    q = 0;
    d_bam = '0;
    if (separation_q != 0) begin
      q = (r * (dr - dl)) / longint'(separation_q);
      prod = longint'(unsigned'(q)) * 64'd683565276;
      d_bam = prod[ddo_pkg::FRAC_BITS +: 32];
    end
    odo_heading += d_bam;
    rotate_angle(odo_heading, sn, cs);
    odo_x = 32'(clamp(longint'(odo_x) + step_q30(d_s, cs), -64'sd2147483648, 64'sd2147483647));
    odo_y = 32'(clamp(longint'(odo_y) + step_q30(d_s, sn), -64'sd2147483648, 64'sd2147483647));
    lin = 0;
    ang = 0;
    if (dt != 0) begin
      lin = clamp((d_s * 1000000) / dt, -64'sd2147483648, 64'sd2147483647);
      ang = clamp((clamp(q, -(64'sd1 <<< 40), 64'sd1 <<< 40) * 1000000) / dt,
                  -64'sd2147483648, 64'sd2147483647);
    end
    rotate_angle(odo_heading >> 1, sn, cs);
    p.pos_x       = odo_x;
    p.pos_y       = odo_y;
    p.heading     = odo_heading;
    p.quat_z      = 32'(sn);
    p.quat_w      = 32'(cs);
    p.linear_vel  = 32'(lin);
    p.angular_vel = 32'(ang);
    p.dt_zero     = (dt == 0);
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH beat %0d %s: got %h want %h", poses_seen, what, got, want);
  endtask

  // Sample driver: hold a stalled beat, otherwise offer the next pending sample
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall)
        expected_poses.insert(expected_poses.size(), odometry_step(sample));
      if (!sample_valid || !sample_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_valid <= 1'b1;
          sample <= pending_samples.pop_front();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Pose monitor: random stall, forced high during a hold-off, check each beat
  always @(posedge clk) begin
    ddo_pkg::pose_t want;
    if (rst) begin
      pose_stall <= 1'b0;
    end else begin
      if (pose_valid && !pose_stall) begin
        poses_seen++;
        if (pose.dt_zero) dt_zero_seen++;
        if (pose.pos_x == 32'sh7fffffff || pose.pos_x == 32'sh80000000) sat_seen++;
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected beat", pose.pos_x, 32'd0);
        end else begin
          want = expected_poses.pop_front();
          if (pose.pos_x != want.pos_x) report_mismatch("pos_x", pose.pos_x, want.pos_x);
          if (pose.pos_y != want.pos_y) report_mismatch("pos_y", pose.pos_y, want.pos_y);
          if (pose.heading != want.heading)
            report_mismatch("heading", pose.heading, want.heading);
          if (pose.quat_z != want.quat_z) report_mismatch("quat_z", pose.quat_z, want.quat_z);
          if (pose.quat_w != want.quat_w) report_mismatch("quat_w", pose.quat_w, want.quat_w);
          if (pose.linear_vel != want.linear_vel)
            report_mismatch("linear_vel", pose.linear_vel, want.linear_vel);
          if (pose.angular_vel != want.angular_vel)
            report_mismatch("angular_vel", pose.angular_vel, want.angular_vel);
          if (pose.dt_zero != want.dt_zero)
            report_mismatch("dt_zero", 32'(pose.dt_zero), 32'(want.dt_zero));
        end
      end
      pose_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Receiver hold-off: count down the requested stretch of cycles
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  assign hold_off = (hold_left > 0);

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Register write with a setup phase and an access phase; mirror the value into the predictor
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ddo_pkg::ADDR_RADIUS) radius_q = data[15:0];
    else separation_q = data[19:0];
  endtask

  task automatic queue_sample(logic [31:0] l, logic [31:0] r, logic [31:0] ts);
    ddo_pkg::sample_t s;
    s.left_wheel_pos = l;
    s.right_wheel_pos = r;
    s.timestamp_us = ts;
    pending_samples.insert(pending_samples.size(), s);
    gen_left = l; gen_right = r; gen_ts = ts;
  endtask

  // Mostly plausible wheel motion with random size; some pure noise samples
  task automatic queue_random(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        queue_sample($urandom, $urandom, $urandom);
      end else begin
        k = $urandom_range(28, 4);
        queue_sample(gen_left + 32'($signed(32'($urandom_range((1 << k) - 1)) - (1 << (k - 1)))),
                     gen_right + 32'($signed(32'($urandom_range((1 << k) - 1)) - (1 << (k - 1)))),
                     gen_ts + (($urandom_range(15) == 0) ? 32'd0 : $urandom_range(20000, 1)));
      end
    end
  endtask

  // Wait until every sample went in and every pose came out, then let the block settle
  task automatic drain();
    while (pending_samples.size() > 0 || sample_valid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    pose_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_left = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    cycle_count = 0;
    mismatches = 0; poses_seen = 0; dt_zero_seen = 0; sat_seen = 0;
    radius_q = 16'd2163; separation_q = 20'd11141;
    last_left = '0; last_right = '0; last_ts = '0;
    odo_x = '0; odo_y = '0; odo_heading = '0;
    gen_left = '0; gen_right = '0; gen_ts = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset configuration: zero step, extreme angles, timestamp wrap
    queue_sample(32'd0, 32'd0, 32'd0);                    // zero time step, no motion
    queue_sample(32'h7fffffff, 32'h80000000, 32'd1);      // opposite extremes, fast spin
    queue_sample(32'h80000000, 32'h7fffffff, 32'd2);
    queue_sample(32'h80000000, 32'h7fffffff, 32'd2);      // same sample again
    queue_sample(32'h00010000, 32'h00010000, 32'hffffffff);
    queue_sample(32'h00020000, 32'h00020000, 32'd0);      // timestamp wraps
    queue_sample(32'h00020000, 32'h00920000, 32'd1000);   // large turn
    queue_sample(32'hffffffff, 32'hffffffff, 32'd1001);
    drain();

    // Largest radius, smallest separation: heading jumps, position saturates
    reg_write(ddo_pkg::ADDR_RADIUS, 32'd65535);
    reg_write(ddo_pkg::ADDR_SEPARATION, 32'd1);
    for (int i = 1; i <= 8; i++)
      queue_sample(gen_left + 32'h40000000, gen_right + 32'h40000000, gen_ts + 32'd1);
    queue_sample(gen_left - 32'h7fffffff, gen_right - 32'h7fffffff, gen_ts + 32'd7);
    queue_sample(gen_left, gen_right + 32'h00000001, gen_ts + 32'hfffffff0);
    drain();

    // Smallest radius, largest separation
    reg_write(ddo_pkg::ADDR_RADIUS, 32'd1);
    reg_write(ddo_pkg::ADDR_SEPARATION, 32'd1048575);
    queue_sample(32'h7fffffff, 32'h7fffffff, gen_ts);
    queue_sample(32'h80000000, 32'h7fffffff, gen_ts + 32'd3);
    drain();

    // Random phases under different handshake pressure
    reg_write(ddo_pkg::ADDR_RADIUS, 32'd2163);
    reg_write(ddo_pkg::ADDR_SEPARATION, 32'd11141);
    queue_random(260);
    drain();

    reg_write(ddo_pkg::ADDR_RADIUS, 32'd65535);
    reg_write(ddo_pkg::ADDR_SEPARATION, 32'd1);
    set_idling(84, 0);
    queue_random(200);
    drain();

    reg_write(ddo_pkg::ADDR_RADIUS, 32'd1);
    reg_write(ddo_pkg::ADDR_SEPARATION, 32'd1048575);
    set_idling(0, 84);
    queue_random(200);
    drain();

    reg_write(ddo_pkg::ADDR_RADIUS, $urandom_range(65535, 1));
    reg_write(ddo_pkg::ADDR_SEPARATION, $urandom_range(1048575, 1));
    set_idling(23, 23);
    queue_random(300);
    drain();

    // Long receiver hold-off while samples keep coming, so the input backs up
    reg_write(ddo_pkg::ADDR_RADIUS, $urandom_range(65535, 1));
    reg_write(ddo_pkg::ADDR_SEPARATION, $urandom_range(1048575, 1));
    set_idling(0, 0);
    queue_random(300);
    @(posedge clk);
    hold_left <= HOLD_CYCLES;
    drain();

    $display("covered %0d pose beats, %0d with zero time step, %0d with x saturated",
             poses_seen, dt_zero_seen, sat_seen);
    $display("register settings included both extremes of radius and separation");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
